// ----- design/sspa_pkg.sv -----
// shared constants, codes and control types for the sonar sweep proximity alarm
`timescale 1ns / 1ps
`default_nettype none
package sspa_pkg;

  // divider geometry: two quotient bits per cycle
  localparam int DIV_W      = 16;
  localparam int DIVR_W     = 8;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // configuration port
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 3;

  // result payload width, rounded up to whole bytes
  localparam int OUT_BITS   = 65;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // echo / 148 taken as ((echo >> 2) * INCH_RECIP) >> 19, exact for 16-bit echoes
  localparam logic [13:0]       INCH_RECIP   = 14'd14170;
  localparam logic [8:0]        SKIP_INCHES  = 9'd155;
  localparam logic [7:0]        MAX_INCHES   = 8'd200;
  localparam logic [6:0]        DUTY_LOW     = 7'd23;
  localparam logic [6:0]        DUTY_HIGH    = 7'd83;
  localparam logic [15:0]       MS_PER_SEC   = 16'd1000;
  localparam logic [7:0]        ALARM_PERIOD = 8'd10;
  localparam logic [7:0]        ALARM_ON     = 8'd5;
  localparam logic [12:0]       SUM_MAX      = 13'd8191;
  localparam logic [15:0]       NEAR_SECONDS = 16'd5;
  localparam logic [15:0]       WARN_STEPS   = 16'd9;
  localparam logic [3:0]        OFF_MAX      = 4'd10;

  // configuration reset values
  localparam logic [4:0] NUM_AVG_RST     = 5'd2;
  localparam logic [9:0] READ_PERIOD_RST = 10'd200;
  localparam logic [4:0] SERVO_STEP_RST  = 5'd7;
  localparam logic [7:0] NEAR_RST        = 8'd12;
  localparam logic [7:0] FAR_RST         = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_AVG     = 3'd0,
    REG_READ_PERIOD = 3'd1,
    REG_SERVO_STEP  = 3'd2,
    REG_NEAR        = 3'd3,
    REG_FAR         = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_TIMING = 2'd0,
    DIV_AVG    = 2'd1
  } div_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_e div_sel;
    logic     timing_upd;
    logic     inch_upd;
    logic     avg_upd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic avg_due;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- design/sonar_sweep_proximity_alarm.sv -----
// top level: sonar sweep proximity alarm, one result per echo reading
// per reading: timing divider pass, average pass if it closes an average, result load
// a new reading is taken only once the previous one is in the result register; the shared
//   radix-4 divider serves both the beeper warning interval and the average
// a new reading is taken while the previous result still waits in the output register
// reset: asynchronous active low, restores config and state registers at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module sonar_sweep_proximity_alarm (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sspa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sspa_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // [15:0] echo_count
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] beep_on, [1] alarm_active, [9:2] average_inches, [16:10] servo_duty,
  // [24:17] event_distance, [40:25] event_time, [48:41] event_angle, [64:49] seconds
  output logic [sspa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tuser   // [0] average_ready
);
  import sspa_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic        beep_on, alarm_active;
  logic [7:0]  average_inches, event_distance, event_angle;
  logic [6:0]  servo_duty;
  logic [15:0] event_time, seconds;

  sspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sspa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .echo_count_i     (s_axis_tdata),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .beep_on_o        (beep_on),
    .alarm_active_o   (alarm_active),
    .average_ready_o  (m_axis_tuser),
    .average_inches_o (average_inches),
    .servo_duty_o     (servo_duty),
    .event_distance_o (event_distance),
    .event_time_o     (event_time),
    .event_angle_o    (event_angle),
    .seconds_o        (seconds)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, seconds, event_angle, event_time,
                         event_distance, servo_duty, average_inches, alarm_active, beep_on};

endmodule
`default_nettype wire

// ----- design/sspa_div.sv -----
// shared restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module sspa_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sspa_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [sspa_pkg::DIVR_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [sspa_pkg::DIV_W-1:0]       quotient_o
);
  import sspa_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q, dvs_d;

  logic [DIVR_W:0] r_a, r_a2, r_b, r_b2;
  logic            ge_a, ge_b;

  always_comb begin
    r_a  = {rem_q, quo_q[DIV_W-1]};
    ge_a = r_a >= {1'b0, dvs_q};
    r_a2 = ge_a ? r_a - {1'b0, dvs_q} : r_a;
    r_b  = {r_a2[DIVR_W-1:0], quo_q[DIV_W-2]};
    ge_b = r_b >= {1'b0, dvs_q};
    r_b2 = ge_b ? r_b - {1'b0, dvs_q} : r_b;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-3:0], ge_a, ge_b};
      rem_d = r_b2[DIVR_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- design/sspa_dp.sv -----
// datapath: config registers, averaging, beeper, servo ramp, time count, result register
`timescale 1ns / 1ps
`default_nettype none
module sspa_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sspa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sspa_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [15:0]                   echo_count_i,
  input  wire sspa_pkg::cmd_t                cmd_i,
  output sspa_pkg::status_t                  status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               beep_on_o,
  output logic                               alarm_active_o,
  output logic                               average_ready_o,
  output logic [7:0]                         average_inches_o,
  output logic [6:0]                         servo_duty_o,
  output logic [7:0]                         event_distance_o,
  output logic [15:0]                        event_time_o,
  output logic [7:0]                         event_angle_o,
  output logic [15:0]                        seconds_o
);
  import sspa_pkg::*;

  // configuration
  logic [4:0] num_avg_q, servo_step_q;
  logic [9:0] period_q;
  logic [7:0] near_q, far_q;

  // architectural state
  logic [12:0] sum_q;
  logic [4:0]  valid_q, taken_q;
  logic [7:0]  avg_q;
  logic [6:0]  pos_q;
  logic        down_q;
  logic [15:0] millis_q, sec_q;
  logic [7:0]  cl_dist_q, cl_angle_q;
  logic [15:0] cl_time_q;
  logic        alarm_q, warn_q, level_q;
  logic [3:0]  off_q;
  logic [7:0]  phase_q;

  // per item
  logic [15:0] echo_q;
  logic [6:0]  duty_q;
  logic        ready_q;
  logic [15:0] incr_q;

  // result register
  logic        ov_q, o_beep_q, o_alarm_q, o_ready_q;
  logic [7:0]  o_avg_q, o_dist_q, o_angle_q;
  logic [6:0]  o_duty_q;
  logic [15:0] o_time_q, o_sec_q;

  logic              div_done;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  div_dnd;
  logic [DIVR_W-1:0] div_dvs;

  sspa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dnd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // divider operand selection
  logic [7:0]  far_gap;
  logic [11:0] far_gap9;
  always_comb begin
    far_gap  = far_q - avg_q;
    far_gap9 = {far_gap, 3'b000} + {4'd0, far_gap};
    case (cmd_i.div_sel)
      DIV_TIMING: begin
        div_dnd = {4'd0, far_gap9};
        div_dvs = far_q - near_q;
      end
      DIV_AVG: begin
        if (valid_q == '0) begin
          div_dnd = {7'd0, SKIP_INCHES};
          div_dvs = 8'd1;
        end else begin
          div_dnd = {3'd0, sum_q};
          div_dvs = {3'd0, valid_q};
        end
      end
      default: begin
        div_dnd = {4'd0, far_gap9};
        div_dvs = far_q - near_q;
      end
    endcase
  end

  // range update and beeper step
  logic       alarm_n, warn_n, level_n, hold;
  logic [3:0] off_n;
  logic [7:0] phase_n;
  always_comb begin
    alarm_n = alarm_q;
    warn_n  = warn_q;
    off_n   = off_q;
    if (avg_q <= near_q && sec_q > NEAR_SECONDS) begin
      alarm_n = 1'b1;
      warn_n  = 1'b0;
    end else if (avg_q <= far_q) begin
      warn_n = 1'b1;
      if (near_q >= far_q) begin
        off_n = 4'd1;
      end else if (quo >= WARN_STEPS) begin
        off_n = 4'd1;
      end else begin
        off_n = OFF_MAX - quo[3:0];
      end
    end else begin
      warn_n = 1'b0;
    end

    level_n = level_q;
    phase_n = phase_q;
    hold    = 1'b0;
    if (alarm_n) begin
      if (phase_q == '0) begin
        level_n = 1'b1;
      end else if (phase_q >= ALARM_ON && level_q) begin
        level_n = 1'b0;
      end else if (phase_q >= ALARM_PERIOD) begin
        phase_n = '0;
        hold    = 1'b1;
      end
    end else if (warn_n) begin
      if (phase_q == '0) begin
        level_n = 1'b1;
      end else if (level_q) begin
        level_n = 1'b0;
      end else if (phase_q >= {4'd0, off_n}) begin
        phase_n = '0;
        hold    = 1'b1;
      end
    end else begin
      level_n = 1'b0;
    end
    // phase saturates at its top
    if (!hold && phase_q != 8'hFF) begin
      phase_n = phase_q + 8'd1;
    end
  end

  // reading accumulation
  logic [27:0] inch_prod;
  logic [8:0]  inches;
  logic [13:0] sum_wide;
  logic [12:0] sum_n;
  logic [4:0]  valid_n, taken_n;
  always_comb begin
    inch_prod = echo_q[15:2] * INCH_RECIP;
    inches    = inch_prod[27:19];
    sum_wide  = {1'b0, sum_q} + {5'd0, inches};
    sum_n     = sum_q;
    valid_n   = valid_q;
    if (inches != SKIP_INCHES) begin
      sum_n   = sum_wide[13] ? SUM_MAX : sum_wide[12:0];
      valid_n = valid_q + 5'd1;
    end
    taken_n = taken_q + 5'd1;
  end

  // average, closest record, servo ramp, time count
  logic [7:0]  avg_n;
  logic [6:0]  pos_off;
  logic [7:0]  angle_n;
  logic [7:0]  pos_up;
  logic [6:0]  pos_n;
  logic        down_n;
  logic [15:0] millis_sum, millis_n, sec_n;
  always_comb begin
    avg_n   = (quo > {8'd0, MAX_INCHES}) ? MAX_INCHES : quo[7:0];
    pos_off = pos_q - DUTY_LOW;
    angle_n = {1'b0, pos_off} + {pos_off, 1'b0};

    pos_up = {1'b0, pos_q} + {3'd0, servo_step_q};
    pos_n  = pos_q;
    down_n = down_q;
    if (down_q) begin
      if ({1'b0, pos_q} <= {1'b0, DUTY_LOW} + {3'd0, servo_step_q}) begin
        pos_n  = DUTY_LOW;
        down_n = 1'b0;
      end else begin
        pos_n = pos_q - {2'd0, servo_step_q};
      end
    end else if (pos_up >= {1'b0, DUTY_HIGH}) begin
      pos_n  = DUTY_HIGH;
      down_n = 1'b1;
    end else if (pos_up <= {1'b0, DUTY_LOW}) begin
      pos_n  = DUTY_LOW;
      down_n = 1'b0;
    end else begin
      pos_n = pos_up[6:0];
    end

    millis_sum = millis_q + incr_q;
    millis_n   = millis_sum;
    sec_n      = sec_q;
    if (millis_sum >= MS_PER_SEC) begin
      millis_n = millis_sum - MS_PER_SEC;
      sec_n    = sec_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_avg_q    <= NUM_AVG_RST;
      period_q     <= READ_PERIOD_RST;
      servo_step_q <= SERVO_STEP_RST;
      near_q       <= NEAR_RST;
      far_q        <= FAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_AVG:     num_avg_q    <= cfg_data_i[4:0];
        REG_READ_PERIOD: period_q     <= cfg_data_i;
        REG_SERVO_STEP:  servo_step_q <= cfg_data_i[4:0];
        REG_NEAR:        near_q       <= cfg_data_i[7:0];
        REG_FAR:         far_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      valid_q    <= '0;
      taken_q    <= '0;
      avg_q      <= '0;
      pos_q      <= DUTY_LOW;
      down_q     <= 1'b0;
      millis_q   <= '0;
      sec_q      <= '0;
      cl_dist_q  <= MAX_INCHES;
      cl_time_q  <= '0;
      cl_angle_q <= '0;
      alarm_q    <= 1'b0;
      warn_q     <= 1'b0;
      off_q      <= '0;
      phase_q    <= '0;
      level_q    <= 1'b0;
      ready_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cmd_i.timing_upd) begin
        alarm_q <= alarm_n;
        warn_q  <= warn_n;
        off_q   <= off_n;
        phase_q <= phase_n;
        level_q <= level_n;
      end
      if (cmd_i.inch_upd) begin
        sum_q   <= sum_n;
        valid_q <= valid_n;
        taken_q <= taken_n;
        ready_q <= status_o.avg_due;
      end
      if (cmd_i.avg_upd) begin
        sum_q   <= '0;
        valid_q <= '0;
        taken_q <= '0;
        avg_q   <= avg_n;
        if (cl_dist_q > avg_n) begin
          cl_dist_q  <= avg_n;
          cl_time_q  <= sec_q;
          cl_angle_q <= angle_n;
        end
        pos_q    <= pos_n;
        down_q   <= down_n;
        millis_q <= millis_n;
        sec_q    <= sec_n;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // config must be held steady while an item is in flight; the block itself does not enforce it
    incr_q <= {11'd0, num_avg_q} * {6'd0, period_q} + {7'd0, period_q[9:1]};
    if (cmd_i.load_item) begin
      echo_q <= echo_count_i;
      duty_q <= pos_q;
    end
    if (cmd_i.out_load) begin
      o_beep_q  <= level_q;
      o_alarm_q <= alarm_q;
      o_ready_q <= ready_q;
      o_avg_q   <= avg_q;
      o_duty_q  <= duty_q;
      o_dist_q  <= cl_dist_q;
      o_time_q  <= cl_time_q;
      o_angle_q <= cl_angle_q;
      o_sec_q   <= sec_q;
    end
  end

  always_comb begin
    status_o.div_done = div_done;
    status_o.avg_due  = taken_n >= num_avg_q;
    status_o.out_busy = ov_q & ~out_ready_i;
  end

  assign out_valid_o      = ov_q;
  assign beep_on_o        = o_beep_q;
  assign alarm_active_o   = o_alarm_q;
  assign average_ready_o  = o_ready_q;
  assign average_inches_o = o_avg_q;
  assign servo_duty_o     = o_duty_q;
  assign event_distance_o = o_dist_q;
  assign event_time_o     = o_time_q;
  assign event_angle_o    = o_angle_q;
  assign seconds_o        = o_sec_q;

endmodule
`default_nettype wire

// ----- design/sspa_ctrl.sv -----
// controller: sequences the divider passes and result hand-off for one reading
`timescale 1ns / 1ps
`default_nettype none
module sspa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sspa_pkg::status_t status_i,
  output sspa_pkg::cmd_t         cmd_o
);
  import sspa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TDIV   = 5'b00010,
    S_ASTART = 5'b00100,
    S_ADIV   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_TIMING;
          state_d         = S_TDIV;
        end
      end
      S_TDIV: begin
        // inches come from the echo register without a divider pass
        if (status_i.div_done) begin
          cmd_o.timing_upd = 1'b1;
          cmd_o.inch_upd   = 1'b1;
          state_d          = status_i.avg_due ? S_ASTART : S_DONE;
        end
      end
      S_ASTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVG;
        state_d         = S_ADIV;
      end
      S_ADIV: begin
        cmd_o.div_sel = DIV_AVG;
        if (status_i.div_done) begin
          cmd_o.avg_upd = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the result register to drain
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the sonar sweep proximity alarm: random echo stream against a predictor
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_PRINTED    = 40;

  localparam int ECHO_PER_INCH  = 148;
  localparam int SKIPPED_RANGE  = 155;
  localparam int RANGE_CAP      = 200;
  localparam int DUTY_MIN       = 23;
  localparam int DUTY_MAX       = 83;
  localparam int MS_SECOND      = 1000;
  localparam int ALARM_CYCLE    = 10;
  localparam int ALARM_HIGH     = 5;
  localparam int SUM_CAP        = 8191;
  localparam int ARM_SECONDS    = 5;
  localparam int WARN_SPAN      = 9;
  localparam int MAX_INCH_BAND  = 441;

  typedef struct packed {
    logic        beep;
    logic        alarm;
    logic        avg_ready;
    logic [7:0]  avg_in;
    logic [6:0]  duty;
    logic [7:0]  ev_dist;
    logic [15:0] ev_time;
    logic [7:0]  ev_angle;
    logic [15:0] secs;
  } sweep_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } stall_mode_e;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic [sspa_pkg::CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [sspa_pkg::CFG_W-1:0]        cfg_data_i    = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [15:0]                       s_axis_tdata  = '0;  // [15:0] echo_count
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // [0] beep_on, [1] alarm_active, [9:2] average_inches, [16:10] servo_duty,
  // [24:17] event_distance, [40:25] event_time, [48:41] event_angle, [64:49] seconds
  logic [sspa_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              m_axis_tuser;         // [0] average_ready

  sonar_sweep_proximity_alarm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the settings
  logic [4:0]  avg_len;
  logic [9:0]  period_ms;
  logic [4:0]  duty_step;
  logic [7:0]  near_in;
  logic [7:0]  far_in;

  // predictor copy of the state
  logic [12:0] run_sum;
  logic [4:0]  run_valid;
  logic [4:0]  run_taken;
  logic [7:0]  avg_dist;
  logic [6:0]  servo_pos;
  logic        sweeping_down;
  logic [15:0] ms_acc;
  logic [15:0] sec_count;
  logic [7:0]  near_dist;
  logic [15:0] near_time;
  logic [7:0]  near_angle;
  logic        alarm_set;
  logic        warn_on;
  logic [11:0] warn_off;
  logic [7:0]  beep_count;
  logic        beeper;

  logic [15:0]   echo_queue[$];
  sweep_result_t pending_results[$];

  int error_count  = 0;
  int result_count = 0;
  int cycle_count  = 0;

  // sender burst control
  int burst_left  = 0;
  int gap_left    = 0;
  int burst_count = 0;
  bit drain_hold  = 1'b0;

  // receiver stall control
  stall_mode_e stall_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          pat_cnt    = 0;

  task automatic reset_predictor();
    avg_len       = 5'd2;
    period_ms     = 10'd200;
    duty_step     = 5'd7;
    near_in       = 8'd12;
    far_in        = 8'd120;
    run_sum       = '0;
    run_valid     = '0;
    run_taken     = '0;
    avg_dist      = '0;
    servo_pos     = 7'(DUTY_MIN);
    sweeping_down = 1'b0;
    ms_acc        = '0;
    sec_count     = '0;
    near_dist     = 8'(RANGE_CAP);
    near_time     = '0;
    near_angle    = '0;
    alarm_set     = 1'b0;
    warn_on       = 1'b0;
    warn_off      = '0;
    beep_count    = '0;
    beeper        = 1'b0;
  endtask

  task automatic predict_reading(input logic [15:0] echo, output sweep_result_t res);
    int unsigned inches;
    int unsigned sum;
    int unsigned avg;
    int unsigned q;
    int unsigned ms;
    int unsigned pos;
    logic        restart;
    logic        done;
    logic [6:0]  duty_now;
    duty_now = servo_pos;
    done     = 1'b0;
    restart  = 1'b0;

    // beeper runs on the average left by earlier readings
    if (avg_dist <= near_in && sec_count > 16'(ARM_SECONDS)) begin
      alarm_set = 1'b1;
      warn_on   = 1'b0;
    end else if (avg_dist <= far_in) begin
      warn_on = 1'b1;
      if (near_in >= far_in) begin
        warn_off = 12'd1;
      end else begin
        q = ((int'(far_in) - int'(avg_dist)) * WARN_SPAN) / (int'(far_in) - int'(near_in));
        warn_off = (q >= WARN_SPAN) ? 12'd1 : 12'(WARN_SPAN + 1 - q);
      end
    end else begin
      warn_on = 1'b0;
    end

    if (alarm_set) begin
      if (beep_count == 0) begin
        beeper = 1'b1;
      end else if (beep_count >= ALARM_HIGH && beeper) begin
        beeper = 1'b0;
      end else if (beep_count >= ALARM_CYCLE) begin
        beep_count = '0;
        restart    = 1'b1;
      end
    end else if (warn_on) begin
      if (beep_count == 0) begin
        beeper = 1'b1;
      end else if (beeper) begin
        beeper = 1'b0;
      end else if (12'(beep_count) >= warn_off) begin
        beep_count = '0;
        restart    = 1'b1;
      end
    end else begin
      beeper = 1'b0;
    end
    if (!restart && beep_count != 8'hFF) beep_count = beep_count + 8'd1;

    inches = int'(echo) / ECHO_PER_INCH;
    if (inches != SKIPPED_RANGE) begin
      sum = int'(run_sum) + inches;
      if (sum > SUM_CAP) sum = SUM_CAP;
      run_sum   = 13'(sum);
      run_valid = run_valid + 5'd1;
    end
    run_taken = run_taken + 5'd1;

    if (run_taken >= avg_len) begin
      if (run_valid == 0) begin
        run_valid = 5'd1;
        run_sum   = 13'(SKIPPED_RANGE);
      end
      run_taken = '0;
      avg       = int'(run_sum) / int'(run_valid);
      run_valid = '0;
      run_sum   = '0;
      if (avg > RANGE_CAP) avg = RANGE_CAP;
      avg_dist = 8'(avg);

      if (near_dist > avg_dist) begin
        near_dist  = avg_dist;
        near_time  = sec_count;
        near_angle = 8'((int'(servo_pos) - DUTY_MIN) * 3);
      end

      pos = servo_pos;
      if (sweeping_down) begin
        if (pos <= DUTY_MIN + int'(duty_step)) begin
          pos           = DUTY_MIN;
          sweeping_down = 1'b0;
        end else begin
          pos = pos - duty_step;
        end
      end else begin
        pos = pos + duty_step;
        if (pos >= DUTY_MAX) begin
          pos           = DUTY_MAX;
          sweeping_down = 1'b1;
        end
        if (pos <= DUTY_MIN) begin
          pos           = DUTY_MIN;
          sweeping_down = 1'b0;
        end
      end
      servo_pos = 7'(pos);

      // at most one second per average
      ms = (int'(ms_acc) + int'(avg_len) * int'(period_ms) + int'(period_ms) / 2) & 32'hFFFF;
      if (ms >= MS_SECOND) begin
        sec_count = sec_count + 16'd1;
        ms        = ms - MS_SECOND;
      end
      ms_acc = 16'(ms);
      done   = 1'b1;
    end

    res.beep      = beeper;
    res.alarm     = alarm_set;
    res.avg_ready = done;
    res.avg_in    = avg_dist;
    res.duty      = duty_now;
    res.ev_dist   = near_dist;
    res.ev_time   = near_time;
    res.ev_angle  = near_angle;
    res.secs      = sec_count;
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_count, field, got, want));
    end
  endtask

  // sender: bursts of transfers with gaps, now and then held until all results are back
  always @(posedge clk_i) begin : drive
    sweep_result_t want;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reading(s_axis_tdata, want);
        pending_results.push_back(want);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (drain_hold) begin
          if (pending_results.size() == 0) drain_hold = 1'b0;
          s_axis_tvalid <= 1'b0;
        end else if (echo_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= echo_queue.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_count++;
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            drain_hold = (burst_count % 6 == 2);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: compares each result transfer, stalls in changing patterns
  always @(posedge clk_i) begin : observe
    sweep_result_t got;
    sweep_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.beep      = m_axis_tdata[0];
        got.alarm     = m_axis_tdata[1];
        got.avg_ready = m_axis_tuser;
        got.avg_in    = m_axis_tdata[9:2];
        got.duty      = m_axis_tdata[16:10];
        got.ev_dist   = m_axis_tdata[24:17];
        got.ev_time   = m_axis_tdata[40:25];
        got.ev_angle  = m_axis_tdata[48:41];
        got.secs      = m_axis_tdata[64:49];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = pending_results.pop_front();
          check_field("beep_on", got.beep, want.beep);
          check_field("alarm_active", got.alarm, want.alarm);
          check_field("average_ready", got.avg_ready, want.avg_ready);
          check_field("average_inches", got.avg_in, want.avg_in);
          check_field("servo_duty", got.duty, want.duty);
          check_field("event_distance", got.ev_dist, want.ev_dist);
          check_field("event_time", got.ev_time, want.ev_time);
          check_field("event_angle", got.ev_angle, want.ev_angle);
          check_field("seconds", got.secs, want.secs);
        end
        result_count++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 400);
      end else begin
        mode_left--;
      end
      pat_cnt++;
      case (stall_mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        READY_SPARSE: m_axis_tready <= (pat_cnt % 9 == 0);
        default:      m_axis_tready <= (pat_cnt % 4 != 3);
      endcase
    end
  end

  task automatic write_reg(input sspa_pkg::cfg_reg_e idx, input logic [9:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      sspa_pkg::REG_NUM_AVG:     avg_len   = value[4:0];
      sspa_pkg::REG_READ_PERIOD: period_ms = value;
      sspa_pkg::REG_SERVO_STEP:  duty_step = value[4:0];
      sspa_pkg::REG_NEAR:        near_in   = value[7:0];
      sspa_pkg::REG_FAR:         far_in    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int n, input int period, input int step_duty,
                            input int near, input int far);
    write_reg(sspa_pkg::REG_NUM_AVG, 10'(n));
    write_reg(sspa_pkg::REG_READ_PERIOD, 10'(period));
    write_reg(sspa_pkg::REG_SERVO_STEP, 10'(step_duty));
    write_reg(sspa_pkg::REG_NEAR, 10'(near));
    write_reg(sspa_pkg::REG_FAR, 10'(far));
  endtask

  // random settings; with keep_clear the near limit stays below every average to come
  task automatic pick_sweep_config(input bit keep_clear, output int lo_in, output int hi_in);
    int n;
    int period;
    int step_duty;
    int near;
    int far;
    int roof;
    case ($urandom_range(0, 7))
      0:       n = 0;
      1:       n = 31;
      2:       n = 16;
      default: n = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 5))
      0:       period = 0;
      1:       period = 1023;
      2:       period = 1000;
      default: period = $urandom_range(1, 1022);
    endcase
    step_duty = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0:       far = 0;
      1:       far = 255;
      default: far = $urandom_range(1, 200);
    endcase
    if (keep_clear) begin
      roof  = (avg_dist > 150) ? 150 : int'(avg_dist) - 1;
      near  = $urandom_range(0, roof);
      lo_in = near + 1;
    end else begin
      near  = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 200);
      lo_in = 0;
    end
    hi_in = far + 40;
    if (hi_in > MAX_INCH_BAND) hi_in = MAX_INCH_BAND;
    if (hi_in < lo_in + 20) hi_in = lo_in + 20;
    // unused upper data bits carry junk that the registers must drop
    write_reg(sspa_pkg::REG_NUM_AVG, {5'($urandom_range(0, 31)), 5'(n)});
    write_reg(sspa_pkg::REG_READ_PERIOD, 10'(period));
    write_reg(sspa_pkg::REG_SERVO_STEP, {5'($urandom_range(0, 31)), 5'(step_duty)});
    write_reg(sspa_pkg::REG_NEAR, {2'($urandom_range(0, 3)), 8'(near)});
    write_reg(sspa_pkg::REG_FAR, {2'($urandom_range(0, 3)), 8'(far)});
  endtask

  function automatic logic [15:0] make_echo(input int lo_in, input int hi_in);
    int unsigned raw;
    case ($urandom_range(0, 9))
      0, 1:    raw = $urandom_range(0, 65535);
      2:       raw = SKIPPED_RANGE * ECHO_PER_INCH + $urandom_range(0, ECHO_PER_INCH - 1);
      default: raw = $urandom_range(lo_in, hi_in) * ECHO_PER_INCH
                     + $urandom_range(0, ECHO_PER_INCH - 1);
    endcase
    if (raw / ECHO_PER_INCH < lo_in) raw = lo_in * ECHO_PER_INCH + raw % ECHO_PER_INCH;
    return 16'(raw);
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (echo_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // whole averages only, so no partial sum crosses a settings change
  task automatic run_readings(input int count, input int lo_in, input int hi_in);
    int total;
    total = count;
    if (avg_len > 1) total = ((count + avg_len - 1) / avg_len) * avg_len;
    repeat (total) echo_queue.push_back(make_echo(lo_in, hi_in));
    wait_idle();
  endtask

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int lo;
    int hi;
    reset_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: echo extremes, skipped range edges, clamp, zero average
    echo_queue.push_back(16'd0);
    echo_queue.push_back(16'd65535);
    echo_queue.push_back(16'(SKIPPED_RANGE * ECHO_PER_INCH));
    echo_queue.push_back(16'(SKIPPED_RANGE * ECHO_PER_INCH + ECHO_PER_INCH - 1));
    echo_queue.push_back(16'(SKIPPED_RANGE * ECHO_PER_INCH - 1));
    echo_queue.push_back(16'((SKIPPED_RANGE + 1) * ECHO_PER_INCH));
    echo_queue.push_back(16'(ECHO_PER_INCH - 1));
    echo_queue.push_back(16'(ECHO_PER_INCH));
    wait_idle();

    // near limit above far limit, time frozen, widest servo step
    set_config(1, 0, 31, 100, 50);
    repeat (5) echo_queue.push_back(16'(30 * ECHO_PER_INCH));
    repeat (2) echo_queue.push_back(16'(60 * ECHO_PER_INCH));
    repeat (2) echo_queue.push_back(16'(30 * ECHO_PER_INCH + 17));
    echo_queue.push_back(16'(ECHO_PER_INCH - 1));
    echo_queue.push_back(16'd65535);
    echo_queue.push_back(16'(SKIPPED_RANGE * ECHO_PER_INCH + 73));
    wait_idle();

    // every reading an average, longest period, servo parked
    set_config(0, 1023, 0, 0, 255);
    run_readings(40, 1, MAX_INCH_BAND);

    // warning beeps across random settings, alarm kept clear
    repeat (6) begin
      pick_sweep_config(1'b1, lo, hi);
      run_readings(70, lo, hi);
    end

    // latch the alarm
    set_config(1, 1000, 7, 150, 200);
    run_readings(30, 0, 140);

    // running sum saturation with the widest average
    set_config(31, 1023, 31, 0, 0);
    run_readings(62, 400, MAX_INCH_BAND);

    // near limit at its top, far limit at zero
    set_config(2, 1, 31, 255, 0);
    run_readings(40, 0, MAX_INCH_BAND);

    repeat (3) begin
      pick_sweep_config(1'b0, lo, hi);
      run_readings(90, lo, hi);
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sspa_pkg.sv
design/sspa_div.sv
design/sspa_dp.sv
design/sspa_ctrl.sv
design/sonar_sweep_proximity_alarm.sv
test/testbench.sv
